/* design/frame_range_set_engine_assert.svh */
// Assertion macros for the frame range set engine
`ifndef FRAME_RANGE_SET_ENGINE_ASSERT_SVH
`define FRAME_RANGE_SET_ENGINE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define FRSE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frse check failed");
// next-cycle implication
`define FRSE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frse check failed");
`endif

/* design/frse_pkg.sv */
`timescale 1ns / 1ps
package frse_pkg;
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;
    localparam logic ST_OK     = 1'b0;
    localparam logic ST_FULL   = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] range_low;
        logic [31:0] range_high;
        logic [31:0] query_index;
    } t_in_beat;

    typedef struct packed {
        logic        status;
        logic        is_covered;
        logic        position_valid;
        logic [31:0] frame_position;
        logic        frame_valid;
        logic [31:0] frame_at_position;
        logic [32:0] total_frames;
        logic [4:0]  ranges_held;
    } t_out_beat;
endpackage

/* design/frse_if.sv */
`timescale 1ns / 1ps
interface frse_in_if;
    logic                valid;
    logic                ready;
    frse_pkg::t_in_beat  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface frse_out_if;
    logic                valid;
    logic                ready;
    frse_pkg::t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/frame_range_set_engine.sv */
`timescale 1ns / 1ps
// One item at a time: each item walks the stored ranges (at most MAX_RANGES),
// reading one entry of the range memory at a time; adds rewrite the kept entries
// in place. A new item is accepted only after the previous result has been taken.
// Reset (synchronous, active low) empties the table; range memory is not cleared.
module frame_range_set_engine #(
    parameter int MAX_RANGES = 16,
    parameter int FRAME_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    frse_in_if.sink    i_item,
    frse_out_if.source o_result
);
    localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int FB = FRAME_BITS;
    localparam int LW = FB + 1;
    localparam int QW = (LW + 1 > 33) ? LW + 1 : 33;
    localparam logic signed [FB:0] ONE_X = (FB+1)'(1);

    typedef enum logic [2:0] {S_IDLE, S_RD, S_PROC, S_INS, S_WR, S_DONE} t_state;

    logic signed [FB-1:0] r_mem_s [MAX_RANGES];
    logic signed [FB-1:0] r_mem_e [MAX_RANGES];

    t_state               r_state;
    logic [CW-1:0]        r_count, r_rd, r_wr, r_merged;
    logic                 r_cmd, r_ins_done, r_ovalid;
    logic signed [FB-1:0] r_lo, r_hi, r_s, r_e;
    logic [31:0]          r_q;
    logic [LW-1:0]        r_acc;
    frse_pkg::t_out_beat  r_out;

    // frame conversion: sign-extend or wrap the 32-bit field
    function automatic logic signed [FB-1:0] to_frame(input logic [31:0] x);
        logic signed [63:0] w;
        w = {{32{x[31]}}, x};
        return w[FB-1:0];
    endfunction

    logic signed [FB:0] lo_x, hi_x, s_x, e_x;
    logic               apart, covered_here, hit_here, before_new;
    logic [LW-1:0]      len;
    logic [QW-1:0]      q_x;
    assign lo_x = {r_lo[FB-1], r_lo};
    assign hi_x = {r_hi[FB-1], r_hi};
    assign s_x  = {r_s[FB-1], r_s};
    assign e_x  = {r_e[FB-1], r_e};
    // shared compare unit: one stored range against the working range
    assign apart = (e_x + ONE_X < lo_x) || (s_x > hi_x + ONE_X);
    assign len   = LW'(e_x - s_x) + LW'(1);
    assign covered_here = (r_lo >= r_s) && (r_lo <= r_e);
    assign q_x   = QW'(r_q);
    assign hit_here = (q_x < QW'(len));
    assign before_new = (r_s < r_lo);

    assign i_item.ready   = (r_state == S_IDLE) && !r_ovalid;
    assign o_result.valid = r_ovalid;
    assign o_result.data  = r_out;

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_result.valid && o_result.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_item.valid && i_item.ready) begin
                        r_cmd      <= i_item.data.cmd;
                        r_q        <= i_item.data.query_index;
                        r_rd       <= '0;
                        r_wr       <= '0;
                        r_merged   <= '0;
                        r_acc      <= '0;
                        r_ins_done <= 1'b0;
                        r_out      <= '0;
                        if (i_item.data.cmd == frse_pkg::CMD_ADD &&
                            $signed(to_frame(i_item.data.range_low)) >
                            $signed(to_frame(i_item.data.range_high))) begin
                            r_lo <= to_frame(i_item.data.range_high);
                            r_hi <= to_frame(i_item.data.range_low);
                        end else begin
                            r_lo <= to_frame(i_item.data.range_low);
                            r_hi <= to_frame(i_item.data.range_high);
                        end
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    if (r_rd == r_count) begin
                        r_state <= S_DONE;
                    end else begin
                        r_s <= r_mem_s[r_rd[IW-1:0]];
                        r_e <= r_mem_e[r_rd[IW-1:0]];
                        r_state <= S_PROC;
                    end
                end
                S_PROC: begin
                    r_rd <= r_rd + 1'b1;
                    if (r_cmd == frse_pkg::CMD_QUERY) begin
                        r_acc <= r_acc + len;
                        r_state <= S_RD;
                        if (!r_out.is_covered && covered_here) begin
                            r_out.is_covered     <= 1'b1;
                            r_out.position_valid <= 1'b1;
                            r_out.frame_position <=
                                32'(r_acc + LW'($unsigned(r_lo - r_s)));
                        end
                        if (!r_out.frame_valid) begin
                            if (hit_here) begin
                                r_out.frame_valid       <= 1'b1;
                                r_out.frame_at_position <= 32'(r_s) + r_q;
                            end else begin
                                r_q <= 32'(q_x - QW'(len));
                            end
                        end
                    end else if (apart) begin
                        // kept entries are compacted in place
                        r_acc <= r_acc + len;
                        if (!before_new && !r_ins_done) r_state <= S_INS;
                        else r_state <= S_WR;
                    end else begin
                        if (r_s < r_lo) r_lo <= r_s;
                        if (r_e > r_hi) r_hi <= r_e;
                        r_merged <= r_merged + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_INS: begin
                    // a kept entry follows the new range; a later merge cannot
                    // reach past a kept entry, so the union is final here
                    if (r_count == CW'(MAX_RANGES) && r_merged == '0) begin
                        // dropped: finish the walk so the total covers every entry
                        r_out.status <= frse_pkg::ST_FULL;
                        r_ins_done <= 1'b1;
                        r_state <= S_WR;
                    end else begin
                        r_mem_s[r_wr[IW-1:0]] <= r_lo;
                        r_mem_e[r_wr[IW-1:0]] <= r_hi;
                        r_acc <= r_acc + LW'(hi_x - lo_x) + LW'(1);
                        r_wr <= r_wr + 1'b1;
                        r_ins_done <= 1'b1;
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    // write back the kept entry while fetching the next one
                    r_mem_s[r_wr[IW-1:0]] <= r_s;
                    r_mem_e[r_wr[IW-1:0]] <= r_e;
                    r_wr <= r_wr + 1'b1;
                    if (r_rd == r_count) begin
                        r_state <= S_DONE;
                    end else begin
                        r_s <= r_mem_s[r_rd[IW-1:0]];
                        r_e <= r_mem_e[r_rd[IW-1:0]];
                        r_state <= S_PROC;
                    end
                end
                S_DONE: begin
                    if (r_cmd == frse_pkg::CMD_ADD && r_out.status == frse_pkg::ST_OK) begin
                        if (r_ins_done) begin
                            r_count <= r_wr;
                            r_out.total_frames <= 33'(r_acc);
                            r_out.ranges_held  <= 5'(r_wr);
                        end else if (r_count == CW'(MAX_RANGES) && r_merged == '0) begin
                            r_out.status       <= frse_pkg::ST_FULL;
                            r_out.total_frames <= 33'(r_acc);
                            r_out.ranges_held  <= 5'(r_count);
                        end else begin
                            r_mem_s[r_wr[IW-1:0]] <= r_lo;
                            r_mem_e[r_wr[IW-1:0]] <= r_hi;
                            r_count <= r_wr + 1'b1;
                            r_out.total_frames <= 33'(r_acc + LW'(hi_x - lo_x) + LW'(1));
                            r_out.ranges_held  <= 5'(r_wr + 1'b1);
                        end
                    end else begin
                        // queries and dropped adds: table untouched
                        r_out.total_frames <= 33'(r_acc);
                        r_out.ranges_held  <= 5'(r_count);
                    end
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `include "frame_range_set_engine_assert.svh"
    `FRSE_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CW'(MAX_RANGES))
    `FRSE_ASSERT_IMP(a_busy_not_ready, r_state != S_IDLE, !i_item.ready)
    `FRSE_ASSERT_NXT(a_done_gives_beat, r_state == S_DONE, r_ovalid)
    `FRSE_ASSERT_IMP(a_valid_flags, r_ovalid, r_out.is_covered == r_out.position_valid)
endmodule
